@@ hdl/idcfr_pkg.sv @@
// ----------------------------------------------------------------------------
// idcfr_pkg
// Shared types, codes and helpers of the id-checked frame receiver.
// ----------------------------------------------------------------------------
package idcfr_pkg;

    localparam int MAX_PAYLOAD_DEF = 256;

    localparam logic [7:0] SYNC_BYTE = 8'hFF;
    localparam logic [7:0] MOD_BASE  = 8'd255;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_OK     = 3'd1;
    localparam logic [2:0] ST_CSUM   = 3'd2;
    localparam logic [2:0] ST_SENDER = 3'd3;
    localparam logic [2:0] ST_RECV   = 3'd4;
    localparam logic [2:0] ST_LONG   = 3'd5;

    localparam logic REG_OWN_ID  = 1'b0;
    localparam logic REG_PEER_ID = 1'b1;

    typedef struct packed {
        logic [7:0] own_id;
        logic [7:0] peer_id;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
        logic [7:0]  frame_sender;
        logic [8:0]  frame_length;
        logic [31:0] frames_received;
    } res_t;

    function automatic logic [7:0] add_mod255(input logic [7:0] s, input logic [7:0] b);
        logic [8:0] t;
        t = {1'b0, s} + {1'b0, b};
        if (t >= {1'b0, MOD_BASE}) t = t - {1'b0, MOD_BASE};
        if (t >= {1'b0, MOD_BASE}) t = t - {1'b0, MOD_BASE};
        return t[7:0];
    endfunction

endpackage

@@ hdl/idcfr_parser.sv @@
// ----------------------------------------------------------------------------
// idcfr_parser
// Frame state step: sync hunt, id checks, length, payload and checksum.
// ----------------------------------------------------------------------------
module idcfr_parser import idcfr_pkg::*; #(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       in_accept,
    input  logic [7:0] in_byte,
    output res_t       res
);

    localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
    localparam logic [16:0] MAX_LEN = 17'(MAX_PAYLOAD);

    typedef enum logic [7:0] {
        PH_SYNC1   = 8'b0000_0001,
        PH_SYNC2   = 8'b0000_0010,
        PH_SENDER  = 8'b0000_0100,
        PH_RECV    = 8'b0000_1000,
        PH_LEN_HI  = 8'b0001_0000,
        PH_LEN_LO  = 8'b0010_0000,
        PH_PAYLOAD = 8'b0100_0000,
        PH_CHECK   = 8'b1000_0000
    } phase_t;

    phase_t             phase_reg,  phase_next;
    logic [7:0]         sum_reg,    sum_next;
    logic [15:0]        len_reg,    len_next;
    logic [CNT_W-1:0]   cnt_reg,    cnt_next;
    logic [7:0]         sender_reg, sender_next;
    logic [31:0]        fc_reg,     fc_next;

    logic [CNT_W-1:0]   cnt_inc;
    logic [15:0]        cnt_ext;
    logic [15:0]        len_lo;
    logic [2:0]         status;
    logic               pvalid;
    logic [7:0]         pbyte;
    logic [7:0]         pindex;

    assign cnt_inc = cnt_reg + CNT_W'(1);
    assign cnt_ext = 16'(cnt_reg);
    assign len_lo  = {len_reg[15:8], in_byte};

    always_comb begin
        phase_next  = phase_reg;
        sum_next    = sum_reg;
        len_next    = len_reg;
        cnt_next    = cnt_reg;
        sender_next = sender_reg;
        fc_next     = fc_reg;
        status      = ST_IDLE;
        pvalid      = 1'b0;
        pbyte       = 8'd0;
        pindex      = 8'd0;
        case (phase_reg)
            PH_SYNC1: begin
                if (in_byte == SYNC_BYTE) begin
                    sum_next   = add_mod255(8'd0, in_byte);
                    len_next   = 16'd0;
                    cnt_next   = '0;
                    phase_next = PH_SYNC2;
                end
            end
            PH_SYNC2: begin
                if (in_byte == SYNC_BYTE) begin
                    sum_next   = add_mod255(sum_reg, in_byte);
                    phase_next = PH_SENDER;
                end else begin
                    phase_next = PH_SYNC1;
                end
            end
            PH_SENDER: begin
                sender_next = in_byte;
                if (in_byte == cfg.peer_id) begin
                    sum_next   = add_mod255(sum_reg, in_byte);
                    phase_next = PH_RECV;
                end else begin
                    status     = ST_SENDER;
                    phase_next = PH_SYNC1;
                end
            end
            PH_RECV: begin
                if (in_byte == cfg.own_id) begin
                    sum_next   = add_mod255(sum_reg, in_byte);
                    phase_next = PH_LEN_HI;
                end else begin
                    status     = ST_RECV;
                    phase_next = PH_SYNC1;
                end
            end
            PH_LEN_HI: begin
                sum_next   = add_mod255(sum_reg, in_byte);
                len_next   = {in_byte, 8'd0};
                phase_next = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                sum_next = add_mod255(sum_reg, in_byte);
                len_next = len_lo;
                if ({1'b0, len_lo} > MAX_LEN) begin
                    status     = ST_LONG;
                    phase_next = PH_SYNC1;
                end else if (len_lo == 16'd0) begin
                    phase_next = PH_CHECK;
                end else begin
                    phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                sum_next = add_mod255(sum_reg, in_byte);
                pvalid   = 1'b1;
                pbyte    = in_byte;
                pindex   = cnt_ext[7:0];
                cnt_next = cnt_inc;
                if (16'(cnt_inc) >= len_reg) phase_next = PH_CHECK;
            end
            PH_CHECK: begin
                if (in_byte == sum_reg) begin
                    status  = ST_OK;
                    fc_next = fc_reg + 32'd1;
                end else begin
                    status  = ST_CSUM;
                end
                sum_next   = 8'd0;
                phase_next = PH_SYNC1;
            end
            default: begin
                phase_next = PH_SYNC1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_SYNC1;
            sum_reg    <= 8'd0;
            len_reg    <= 16'd0;
            cnt_reg    <= '0;
            sender_reg <= 8'd0;
            fc_reg     <= 32'd0;
        end else if (in_accept) begin
            phase_reg  <= phase_next;
            sum_reg    <= sum_next;
            len_reg    <= len_next;
            cnt_reg    <= cnt_next;
            sender_reg <= sender_next;
            fc_reg     <= fc_next;
        end
    end

    always_comb begin
        res.status          = status;
        res.payload_valid   = pvalid;
        res.payload_byte    = pbyte;
        res.payload_index   = pindex;
        res.frame_sender    = sender_next;
        res.frame_length    = (len_next[15:9] != 7'd0) ? 9'h1FF : len_next[8:0];
        res.frames_received = fc_next;
    end

endmodule

@@ hdl/idcfr_out_buf.sv @@
// ----------------------------------------------------------------------------
// idcfr_out_buf
// Result register with a skid stage so a request is taken while one waits.
// ----------------------------------------------------------------------------
module idcfr_out_buf import idcfr_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  res_t push_data,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    output res_t out_data
);

    logic out_valid_reg,  out_valid_next;
    logic skid_valid_reg, skid_valid_next;
    res_t out_data_reg,   out_data_next;
    res_t skid_data_reg,  skid_data_next;
    logic pop;

    assign pop       = out_valid_reg && out_ready;
    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            if (pop) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!out_valid_reg || pop) begin
                out_data_next  = push_data;
                out_valid_next = 1'b1;
            end else begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
        end else if (pop) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

@@ hdl/id_checked_frame_receiver_top.sv @@
// ----------------------------------------------------------------------------
// id_checked_frame_receiver_top
// Byte-serial frame receiver: sync hunt, id checks, length, payload, checksum.
// A taken byte's result is registered in the result register, or in the skid stage.
// One byte is taken per cycle while the skid stage is empty.
// The result register and skid stage keep input taken while one result waits.
// Reset (aresetn, synchronous): hunting for sync, counters and sums cleared,
// own_id 1 and peer_id 0.
// ----------------------------------------------------------------------------
module id_checked_frame_receiver_top import idcfr_pkg::*; #(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic        m_payload_valid,
    output logic [7:0]  m_payload_byte,
    output logic [7:0]  m_payload_index,
    output logic [7:0]  m_frame_sender,
    output logic [8:0]  m_frame_length,
    output logic [31:0] m_frames_received
);

    cfg_t cfg_reg, cfg_next;
    res_t step_res;
    res_t out_res;
    logic in_accept;
    logic wr_en;

    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite && pready;
    assign in_accept = s_valid && s_ready;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (paddr[2])
                REG_OWN_ID:  cfg_next.own_id  = pwdata[7:0];
                REG_PEER_ID: cfg_next.peer_id = pwdata[7:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.own_id  <= 8'd1;
            cfg_reg.peer_id <= 8'd0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (paddr[2])
            REG_OWN_ID:  prdata = {24'd0, cfg_reg.own_id};
            REG_PEER_ID: prdata = {24'd0, cfg_reg.peer_id};
            default:     prdata = 32'd0;
        endcase
    end

    idcfr_parser #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_accept (in_accept),
        .in_byte   (s_rx_byte),
        .res       (step_res)
    );

    idcfr_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (in_accept),
        .push_data (step_res),
        .in_ready  (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_res)
    );

    assign m_status          = out_res.status;
    assign m_payload_valid   = out_res.payload_valid;
    assign m_payload_byte    = out_res.payload_byte;
    assign m_payload_index   = out_res.payload_index;
    assign m_frame_sender    = out_res.frame_sender;
    assign m_frame_length    = out_res.frame_length;
    assign m_frames_received = out_res.frames_received;

`ifndef SYNTHESIS
    // after every taken request a result is valid on the next cycle
    a_push_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted byte produced no result");

    // input is only stalled when both result slots are occupied
    a_stall_means_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with empty result register");

    // payload bytes never carry a frame verdict
    a_payload_no_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload_valid |-> m_status == ST_IDLE)
        else $error("payload byte with non-idle status");
`endif

endmodule

@@ tb/sv/frame_rx_checker.sv @@
// ----------------------------------------------------------------------------
// frame_rx_checker
// Watches the byte, result and register ports of the frame receiver, keeps
// its own copy of the receive state and the ids, predicts the result of each
// byte request and compares every result, field by field, in order.
// ----------------------------------------------------------------------------
module frame_rx_checker import idcfr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [2:0]  m_status,
    input  logic        m_payload_valid,
    input  logic [7:0]  m_payload_byte,
    input  logic [7:0]  m_payload_index,
    input  logic [7:0]  m_frame_sender,
    input  logic [8:0]  m_frame_length,
    input  logic [31:0] m_frames_received,
    output int unsigned mismatches,
    output int unsigned awaited
);

    typedef enum logic [2:0] {
        HUNT_SYNC1,
        HUNT_SYNC2,
        TAKE_SENDER,
        TAKE_RECEIVER,
        TAKE_LEN_HI,
        TAKE_LEN_LO,
        TAKE_PAYLOAD,
        TAKE_CHECKSUM
    } rx_phase_t;

    localparam logic [2:0]  OWN_ID_ADDR  = {REG_OWN_ID, 2'b00};
    localparam logic [2:0]  PEER_ID_ADDR = {REG_PEER_ID, 2'b00};
    localparam logic [15:0] LEN_LIMIT    = 16'(MAX_PAYLOAD_DEF);

    rx_phase_t   rx_phase;
    logic [7:0]  link_sum;
    logic [15:0] frame_len;
    logic [15:0] taken;
    logic [7:0]  last_sender;
    logic [31:0] good_frames;
    logic [7:0]  own_id;
    logic [7:0]  peer_id;
    res_t        awaited_results[$];

    // running sum stays below 255, so one fold is enough
    function automatic logic [7:0] sum_mod255(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] t;
        t = {1'b0, a} + {1'b0, b};
        if (t >= 9'd255) t = t - 9'd255;
        return t[7:0];
    endfunction

    function automatic res_t receive_byte(input logic [7:0] b);
        res_t r;
        r = '0;
        r.status = ST_IDLE;
        case (rx_phase)
            HUNT_SYNC1: begin
                if (b == SYNC_BYTE) begin
                    link_sum  = sum_mod255(8'd0, b);
                    frame_len = '0;
                    taken     = '0;
                    rx_phase  = HUNT_SYNC2;
                end
            end
            HUNT_SYNC2: begin
                if (b == SYNC_BYTE) begin
                    link_sum = sum_mod255(link_sum, b);
                    rx_phase = TAKE_SENDER;
                end else begin
                    rx_phase = HUNT_SYNC1;
                end
            end
            TAKE_SENDER: begin
                last_sender = b;
                if (b == peer_id) begin
                    link_sum = sum_mod255(link_sum, b);
                    rx_phase = TAKE_RECEIVER;
                end else begin
                    r.status = ST_SENDER;
                    rx_phase = HUNT_SYNC1;
                end
            end
            TAKE_RECEIVER: begin
                if (b == own_id) begin
                    link_sum = sum_mod255(link_sum, b);
                    rx_phase = TAKE_LEN_HI;
                end else begin
                    r.status = ST_RECV;
                    rx_phase = HUNT_SYNC1;
                end
            end
            TAKE_LEN_HI: begin
                link_sum  = sum_mod255(link_sum, b);
                frame_len = {b, 8'h00};
                rx_phase  = TAKE_LEN_LO;
            end
            TAKE_LEN_LO: begin
                link_sum       = sum_mod255(link_sum, b);
                frame_len[7:0] = b;
                if (frame_len > LEN_LIMIT) begin
                    r.status = ST_LONG;
                    rx_phase = HUNT_SYNC1;
                end else if (frame_len == '0) begin
                    rx_phase = TAKE_CHECKSUM;
                end else begin
                    rx_phase = TAKE_PAYLOAD;
                end
            end
            TAKE_PAYLOAD: begin
                link_sum        = sum_mod255(link_sum, b);
                r.payload_valid = 1'b1;
                r.payload_byte  = b;
                r.payload_index = taken[7:0];
                taken           = taken + 16'd1;
                if (taken >= frame_len) rx_phase = TAKE_CHECKSUM;
            end
            TAKE_CHECKSUM: begin
                if (b == link_sum) begin
                    r.status    = ST_OK;
                    good_frames = good_frames + 32'd1;
                end else begin
                    r.status = ST_CSUM;
                end
                link_sum = '0;
                rx_phase = HUNT_SYNC1;
            end
            default: rx_phase = HUNT_SYNC1;
        endcase
        r.frame_sender    = last_sender;
        r.frame_length    = (frame_len > 16'd511) ? 9'h1FF : frame_len[8:0];
        r.frames_received = good_frames;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
            report_mismatch($sformatf("%s: want 0x%0h, got 0x%0h", name, want, got));
    endtask

    always @(posedge aclk) begin
        res_t want;
        if (!aresetn) begin
            rx_phase    = HUNT_SYNC1;
            link_sum    = '0;
            frame_len   = '0;
            taken       = '0;
            last_sender = '0;
            good_frames = '0;
            own_id      = 8'd1;
            peer_id     = 8'd0;
            mismatches  = 0;
            awaited_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch("result with no byte request outstanding");
                end else begin
                    want = awaited_results.pop_front();
                    check_field("status", 32'(want.status), 32'(m_status));
                    check_field("payload_valid", 32'(want.payload_valid),
                                32'(m_payload_valid));
                    check_field("payload_byte", 32'(want.payload_byte), 32'(m_payload_byte));
                    check_field("payload_index", 32'(want.payload_index),
                                32'(m_payload_index));
                    check_field("frame_sender", 32'(want.frame_sender), 32'(m_frame_sender));
                    check_field("frame_length", 32'(want.frame_length), 32'(m_frame_length));
                    check_field("frames_received", want.frames_received, m_frames_received);
                end
            end
            if (psel && penable && pwrite && pready) begin
                if (paddr == OWN_ID_ADDR) own_id = pwdata[7:0];
                else if (paddr == PEER_ID_ADDR) peer_id = pwdata[7:0];
            end
            if (s_valid && s_ready) awaited_results.push_back(receive_byte(s_rx_byte));
        end
        awaited = awaited_results.size();
    end

endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Drives the frame receiver with directed corner frames and then with mostly
// well-formed random frames, mixed with broken frames and line noise, under
// several id settings, bursty byte requests and a stalling result side. The
// checker beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb import idcfr_pkg::*;;

    localparam logic [2:0] OWN_ID_ADDR  = {REG_OWN_ID, 2'b00};
    localparam logic [2:0] PEER_ID_ADDR = {REG_PEER_ID, 2'b00};
    localparam int unsigned PHASE_BYTES = 115;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_rx_byte;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_status;
    logic        m_payload_valid;
    logic [7:0]  m_payload_byte;
    logic [7:0]  m_payload_index;
    logic [7:0]  m_frame_sender;
    logic [8:0]  m_frame_length;
    logic [31:0] m_frames_received;

    int unsigned mismatches;
    int unsigned awaited;

    logic        calm;
    int unsigned burst_left;
    int unsigned bytes_sent;
    logic [7:0]  cur_own;
    logic [7:0]  cur_peer;
    logic [7:0]  link_bytes[$];
    logic [15:0] stall_pat = 16'h0001;
    logic [5:0]  stall_age = '0;

    always #4 aclk = ~aclk;

    id_checked_frame_receiver_top uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_rx_byte         (s_rx_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_payload_valid   (m_payload_valid),
        .m_payload_byte    (m_payload_byte),
        .m_payload_index   (m_payload_index),
        .m_frame_sender    (m_frame_sender),
        .m_frame_length    (m_frame_length),
        .m_frames_received (m_frames_received)
    );

    frame_rx_checker u_frame_check (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .pready            (pready),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_rx_byte         (s_rx_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_payload_valid   (m_payload_valid),
        .m_payload_byte    (m_payload_byte),
        .m_payload_index   (m_payload_index),
        .m_frame_sender    (m_frame_sender),
        .m_frame_length    (m_frame_length),
        .m_frames_received (m_frames_received),
        .mismatches        (mismatches),
        .awaited           (awaited)
    );

    // result side stalls on a rotating pattern, reloaded each time stall_age wraps; calm holds m_ready high
    always @(negedge aclk) begin
        stall_age = stall_age + 6'd1;
        if (stall_age == '0) stall_pat = 16'($urandom) | 16'h0001;
        else stall_pat = {stall_pat[14:0], stall_pat[15]};
        m_ready = calm | stall_pat[0];
    end

    function automatic logic [7:0] csum_add(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] t;
        t = {1'b0, a} + {1'b0, b};
        if (t >= 9'd255) t = t - 9'd255;
        return t[7:0];
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = calm ? 0 : $urandom_range(0, 6);
            if (gap != 0) begin
                s_valid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_valid   = 1'b1;
        s_rx_byte = b;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic send_queued();
        while (link_bytes.size() != 0) send_byte(link_bytes.pop_front());
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [7:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = {24'd0, value};
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        if (addr == OWN_ID_ADDR) cur_own = value;
        else cur_peer = value;
    endtask

    task automatic settle();
        s_valid = 1'b0;
        while (awaited != 0) @(negedge aclk);
        repeat (2) @(negedge aclk);
    endtask

    // oversized lengths get the header only, as the receiver drops them there
    task automatic queue_frame(input logic [7:0] snd, input logic [7:0] rcv,
                               input logic [15:0] len, input logic bad_sum);
        logic [7:0] head [6];
        logic [7:0] csum;
        logic [7:0] b;
        head = '{SYNC_BYTE, SYNC_BYTE, snd, rcv, len[15:8], len[7:0]};
        csum = 8'd0;
        foreach (head[i]) begin
            link_bytes.push_back(head[i]);
            csum = csum_add(csum, head[i]);
        end
        if (len > 16'(MAX_PAYLOAD_DEF)) return;
        repeat (len) begin
            b = 8'($urandom);
            link_bytes.push_back(b);
            csum = csum_add(csum, b);
        end
        if (bad_sum) csum = csum ^ 8'($urandom_range(1, 255));
        link_bytes.push_back(csum);
    endtask

    task automatic queue_random_traffic();
        int unsigned pick;
        logic [15:0] len;
        logic [15:0] long_len;
        pick     = $urandom_range(0, 99);
        len      = ($urandom_range(0, 29) == 0) ? 16'($urandom_range(250, 256))
                                                : 16'($urandom_range(0, 12));
        long_len = $urandom_range(0, 1) ? 16'($urandom_range(257, 511))
                                        : 16'($urandom_range(512, 65535));
        if (pick < 72) begin
            queue_frame(cur_peer, cur_own, len, 1'b0);
        end else if (pick < 80) begin
            queue_frame(cur_peer, cur_own, len, 1'b1);
        end else if (pick < 84) begin
            queue_frame(cur_peer ^ 8'($urandom_range(1, 255)), cur_own, len, 1'b0);
        end else if (pick < 88) begin
            queue_frame(cur_peer, cur_own ^ 8'($urandom_range(1, 255)), len, 1'b0);
        end else if (pick < 92) begin
            queue_frame(cur_peer, cur_own, long_len, 1'b0);
        end else if (pick < 96) begin
            link_bytes.push_back(SYNC_BYTE);
            link_bytes.push_back(8'($urandom_range(0, 254)));
        end else begin
            repeat ($urandom_range(1, 6)) link_bytes.push_back(8'($urandom));
        end
    endtask

    initial begin
        int unsigned phase_start;
        logic [7:0] own_v;
        logic [7:0] peer_v;
        aresetn    = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        s_valid    = 1'b0;
        s_rx_byte  = '0;
        calm       = 1'b0;
        burst_left = 0;
        bytes_sent = 0;
        cur_own    = 8'd1;
        cur_peer   = 8'd0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed corners under the reset ids
        send_byte(8'h00);
        send_byte(SYNC_BYTE);
        send_byte(8'h00);
        send_byte(SYNC_BYTE);
        send_byte(SYNC_BYTE);
        send_byte(8'h55);
        send_byte(SYNC_BYTE);
        send_byte(SYNC_BYTE);
        send_byte(cur_peer);
        send_byte(8'h7E);
        queue_frame(cur_peer, cur_own, 16'hFFFF, 1'b0);
        queue_frame(cur_peer, cur_own, 16'd0, 1'b0);
        send_queued();
        settle();

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: begin own_v = 8'hFF; peer_v = 8'hFF; end
                1: begin own_v = 8'h00; peer_v = 8'hFF; end
                2: begin own_v = 8'hFF; peer_v = 8'h00; end
                3: begin own_v = 8'($urandom); peer_v = 8'($urandom); end
                4: begin own_v = 8'h00; peer_v = 8'h00; end
                default: begin own_v = 8'h01; peer_v = 8'h00; end
            endcase
            write_reg(OWN_ID_ADDR, own_v);
            write_reg(PEER_ID_ADDR, peer_v);
            calm        = (p == 2);
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES) begin
                queue_random_traffic();
                send_queued();
            end
            settle();
        end

        calm = 1'b0;
        repeat (4) @(negedge aclk);
        if (mismatches == 0 && awaited == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ files.f @@
hdl/idcfr_pkg.sv
hdl/idcfr_parser.sv
hdl/idcfr_out_buf.sv
hdl/id_checked_frame_receiver_top.sv
tb/sv/frame_rx_checker.sv
tb/sv/tb.sv
